[rtl/vpa_pkg.sv]
// Shared types, constants and the sine/cosine table builder for the YCbCr proc amp
`timescale 1ns / 1ps
`default_nettype none

package vpa_pkg;

    // default data path sizes
    localparam int VPA_PIXEL_BITS     = 8;
    localparam int VPA_TRIG_FRAC_BITS = 14;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // register reset values
    localparam logic [9:0] CONTRAST_RST   = 10'd256;
    localparam logic [8:0] BRIGHTNESS_RST = 9'd0;
    localparam logic [9:0] SATURATION_RST = 10'd256;
    localparam logic [8:0] HUE_RST        = 9'd0;
    localparam logic [8:0] CB_OFFSET_RST  = 9'd0;
    localparam logic [8:0] CR_OFFSET_RST  = 9'd0;
    localparam logic [9:0] CB_GAIN_RST    = 10'd256;
    localparam logic [9:0] CR_GAIN_RST    = 10'd256;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTRAST   = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_SATURATION = 3'd2,
        REG_HUE        = 3'd3,
        REG_CB_OFFSET  = 3'd4,
        REG_CR_OFFSET  = 3'd5,
        REG_CB_GAIN    = 3'd6,
        REG_CR_GAIN    = 3'd7
    } reg_idx_t;

    // register file contents; signed fields are two's complement bit patterns
    typedef struct packed {
        logic [9:0] contrast;
        logic [8:0] brightness;
        logic [9:0] saturation;
        logic [8:0] hue;
        logic [8:0] cb_offset;
        logic [8:0] cr_offset;
        logic [9:0] cb_gain;
        logic [9:0] cr_gain;
    } cfg_t;

    // per-stage load enables of the pixel pipeline
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
        logic en_d;
    } pipe_ctl_t;

    // hue quadrant
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // sine/cosine table over one quadrant, wide enough for Q1.16
    localparam int TRIG_TAB_W   = 18;
    localparam int TRIG_TAB_LEN = 90;
    typedef logic signed [TRIG_TAB_W-1:0] trig_tab_t [0:TRIG_TAB_LEN-1];

    // pi/180 in Q30
    localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;

    // t * x^2 in Q30
    function automatic longint unsigned sq_step(longint unsigned t, longint unsigned x);
        return (((t * x) >> 30) * x) >> 30;
    endfunction

    // Taylor sine, angle 0..45 degrees, Q30
    function automatic longint unsigned series_sin(int unsigned a);
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        x = longint'(a) * DEG_TO_RAD_Q30;
        t = x;
        s = x;
        t = sq_step(t, x) / 6;
        s = s - t;
        t = sq_step(t, x) / 20;
        s = s + t;
        t = sq_step(t, x) / 42;
        s = s - t;
        t = sq_step(t, x) / 72;
        s = s + t;
        return s;
    endfunction

    // Taylor cosine, angle 0..45 degrees, Q30
    function automatic longint unsigned series_cos(int unsigned a);
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        x = longint'(a) * DEG_TO_RAD_Q30;
        t = 64'd1 << 30;
        s = t;
        t = sq_step(t, x) / 2;
        s = s - t;
        t = sq_step(t, x) / 12;
        s = s + t;
        t = sq_step(t, x) / 30;
        s = s - t;
        t = sq_step(t, x) / 56;
        s = s + t;
        t = sq_step(t, x) / 90;
        s = s - t;
        return s;
    endfunction

    // Q30 to Q1.frac, round half up
    function automatic logic signed [TRIG_TAB_W-1:0] q30_to_trig(longint unsigned v, int frac);
        longint unsigned r;
        r = (v + (64'd1 << (29 - frac))) >> (30 - frac);
        return TRIG_TAB_W'(r);
    endfunction

    // first-quadrant table, folded about 45 degrees; evaluated at elaboration
    function automatic trig_tab_t build_trig_tab(int frac, bit want_cos);
        trig_tab_t tab;
        for (int unsigned a = 0; a < TRIG_TAB_LEN; a++) begin
            if (a <= 45) begin
                tab[a] = want_cos ? q30_to_trig(series_cos(a), frac)
                                  : q30_to_trig(series_sin(a), frac);
            end else begin
                tab[a] = want_cos ? q30_to_trig(series_sin(90 - a), frac)
                                  : q30_to_trig(series_cos(90 - a), frac);
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

[rtl/vpa_cfg.sv]
// Configuration register file of the YCbCr proc amp
`timescale 1ns / 1ps
`default_nettype none

module vpa_cfg import vpa_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_wr_index))
                REG_CONTRAST:   cfg_next.contrast   = cfg_wr_data;
                REG_BRIGHTNESS: cfg_next.brightness = cfg_wr_data[8:0];
                REG_SATURATION: cfg_next.saturation = cfg_wr_data;
                REG_HUE:        cfg_next.hue        = cfg_wr_data[8:0];
                REG_CB_OFFSET:  cfg_next.cb_offset  = cfg_wr_data[8:0];
                REG_CR_OFFSET:  cfg_next.cr_offset  = cfg_wr_data[8:0];
                REG_CB_GAIN:    cfg_next.cb_gain    = cfg_wr_data;
                REG_CR_GAIN:    cfg_next.cr_gain    = cfg_wr_data;
            endcase
        end
    end

    // register state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.contrast   <= CONTRAST_RST;
            cfg_reg.brightness <= BRIGHTNESS_RST;
            cfg_reg.saturation <= SATURATION_RST;
            cfg_reg.hue        <= HUE_RST;
            cfg_reg.cb_offset  <= CB_OFFSET_RST;
            cfg_reg.cr_offset  <= CR_OFFSET_RST;
            cfg_reg.cb_gain    <= CB_GAIN_RST;
            cfg_reg.cr_gain    <= CR_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/vpa_trig.sv]
// Hue angle to sine and cosine by quadrant folding and a one-quadrant table
`timescale 1ns / 1ps
`default_nettype none

module vpa_trig import vpa_pkg::*; #(
    parameter int TRIG_FRAC_BITS = VPA_TRIG_FRAC_BITS
) (
    input  wire logic [8:0]                     hue,
    output logic signed [TRIG_FRAC_BITS+1:0]    sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0]    cos_val
);

    localparam int TW = TRIG_FRAC_BITS + 2;

    localparam trig_tab_t SIN_TAB = build_trig_tab(TRIG_FRAC_BITS, 1'b0);
    localparam trig_tab_t COS_TAB = build_trig_tab(TRIG_FRAC_BITS, 1'b1);

    logic [8:0]           deg;
    logic [6:0]           ang;
    quad_t                quad;
    logic signed [TW-1:0] s0;
    logic signed [TW-1:0] c0;

    // wrap to 0..359 and split into quadrant and angle within it
    always_comb begin
        deg = hue[8] ? (hue + 9'd360) : hue;
        priority if (deg >= 9'd270) begin
            quad = QUAD_3;
            ang  = 7'(deg - 9'd270);
        end else if (deg >= 9'd180) begin
            quad = QUAD_2;
            ang  = 7'(deg - 9'd180);
        end else if (deg >= 9'd90) begin
            quad = QUAD_1;
            ang  = 7'(deg - 9'd90);
        end else begin
            quad = QUAD_0;
            ang  = deg[6:0];
        end
    end

    // table read
    assign s0 = SIN_TAB[ang][TW-1:0];
    assign c0 = COS_TAB[ang][TW-1:0];

    // quadrant mapping
    always_comb begin
        unique case (quad)
            QUAD_0: begin
                sin_val = s0;
                cos_val = c0;
            end
            QUAD_1: begin
                sin_val = c0;
                cos_val = -s0;
            end
            QUAD_2: begin
                sin_val = -s0;
                cos_val = -c0;
            end
            QUAD_3: begin
                sin_val = -c0;
                cos_val = s0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/vpa_luma.sv]
// Luma pipeline: contrast gain, brightness offset, round and clamp
`timescale 1ns / 1ps
`default_nettype none

module vpa_luma import vpa_pkg::*; #(
    parameter int PIXEL_BITS = VPA_PIXEL_BITS
) (
    input  wire logic                  aclk,
    input  wire pipe_ctl_t             ctl,
    input  wire logic [PIXEL_BITS-1:0] luma_in,
    input  wire logic [9:0]            contrast,
    input  wire logic [8:0]            brightness,
    output logic [PIXEL_BITS-1:0]      luma_out
);

    localparam int P   = PIXEL_BITS;
    localparam int PRW = P + 10;
    localparam int LW  = P + 16;
    localparam int QW  = LW - 10;
    localparam logic [P-1:0] PIX_MAX = {P{1'b1}};

    logic [PRW-1:0]        prod_reg;
    logic [PRW-1:0]        prod_next;
    logic signed [11:0]    off_reg;
    logic signed [11:0]    off_next;
    logic signed [LW-1:0]  sum_reg;
    logic signed [LW-1:0]  sum_next;
    logic [P-1:0]          clip_reg;
    logic [P-1:0]          clip_next;
    logic [P-1:0]          out_reg;
    logic [QW-1:0]         quot;

    // stage a: gain product and the constant offset term 256 + 2*bri - con
    assign prod_next = PRW'(contrast) * PRW'(luma_in);
    assign off_next  = 12'sd256 + (12'(signed'(brightness)) <<< 1) - signed'(12'(contrast));

    // stage b: 2*con*y + max*offset, plus half an lsb of the 2^9 scale
    assign sum_next = (LW'(prod_reg) << 1) + LW'(signed'({1'b0, PIX_MAX})) * LW'(off_reg)
                    + LW'(256);

    // stage c: scale down and clamp
    assign quot = sum_reg[LW-2:9];
    always_comb begin
        priority if (sum_reg[LW-1]) begin
            clip_next = '0;
        end else if (|quot[QW-1:P]) begin
            clip_next = PIX_MAX;
        end else begin
            clip_next = quot[P-1:0];
        end
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (ctl.en_a) begin
            prod_reg <= prod_next;
            off_reg  <= off_next;
        end
        if (ctl.en_b) begin
            sum_reg <= sum_next;
        end
        if (ctl.en_c) begin
            clip_reg <= clip_next;
        end
        if (ctl.en_d) begin
            out_reg <= clip_reg;
        end
    end

    assign luma_out = out_reg;

endmodule

`default_nettype wire

[rtl/vpa_chroma.sv]
// Chroma pipeline for one output channel: rotate, scale, offset, round and clamp
`timescale 1ns / 1ps
`default_nettype none

module vpa_chroma import vpa_pkg::*; #(
    parameter int PIXEL_BITS     = VPA_PIXEL_BITS,
    parameter int TRIG_FRAC_BITS = VPA_TRIG_FRAC_BITS
) (
    input  wire logic                           aclk,
    input  wire pipe_ctl_t                      ctl,
    input  wire logic [PIXEL_BITS-1:0]          cb_in,
    input  wire logic [PIXEL_BITS-1:0]          cr_in,
    input  wire logic signed [TRIG_FRAC_BITS+1:0] coef_a,
    input  wire logic signed [TRIG_FRAC_BITS+1:0] coef_b,
    input  wire logic [9:0]                     saturation,
    input  wire logic [9:0]                     chan_gain,
    input  wire logic [8:0]                     chan_offset,
    output logic [PIXEL_BITS-1:0]               chroma_out
);

    localparam int P  = PIXEL_BITS;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int CW = P + 1;
    localparam int RW = F + P + 2;
    localparam int GW = 20;
    localparam int PW = RW + GW;
    localparam int NW = PW + 1;
    localparam int SH = 17 + F;
    localparam int QW = NW - 1 - SH;
    localparam logic [P-1:0] PIX_MAX = {P{1'b1}};
    // centre max/2 in the 2^SH scale plus half an lsb for rounding
    localparam logic signed [NW-1:0] CENTRE_HALF = (NW'(PIX_MAX) << (16 + F))
                                                 + (NW'(1) << (SH - 1));

    logic signed [CW-1:0] cb2_reg;
    logic signed [CW-1:0] cb2_next;
    logic signed [CW-1:0] cr2_reg;
    logic signed [CW-1:0] cr2_next;
    logic signed [TW-1:0] coef_a_reg;
    logic signed [TW-1:0] coef_b_reg;
    logic [GW-1:0]        gain_a_reg;
    logic [GW-1:0]        gain_a_next;
    logic [GW-1:0]        gain_b_reg;
    logic signed [RW-1:0] rot_reg;
    logic signed [RW-1:0] rot_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [NW-1:0] ofs_reg;
    logic signed [NW-1:0] ofs_next;
    logic [P-1:0]         out_reg;
    logic [P-1:0]         out_next;
    logic signed [NW-1:0] sum;
    logic [QW-1:0]        quot;

    // stage a: chroma about the centre in half-lsb units, combined gain
    assign cb2_next    = CW'(signed'({1'b0, cb_in, 1'b0}) - signed'({2'b00, PIX_MAX}));
    assign cr2_next    = CW'(signed'({1'b0, cr_in, 1'b0}) - signed'({2'b00, PIX_MAX}));
    assign gain_a_next = GW'(saturation) * GW'(chan_gain);

    // stage b: hue rotation a*cb - b*cr
    assign rot_next = RW'(coef_a_reg) * RW'(cb2_reg) - RW'(coef_b_reg) * RW'(cr2_reg);

    // stage c: gain product, and centre plus channel offset
    assign prod_next = PW'(signed'({1'b0, gain_b_reg})) * PW'(rot_reg);
    assign ofs_next  = CENTRE_HALF
                     + ((NW'(signed'({1'b0, PIX_MAX})) * NW'(signed'(chan_offset))) <<< (9 + F));

    // stage d: final sum, scale down and clamp
    assign sum  = NW'(prod_reg) + ofs_reg;
    assign quot = sum[NW-2:SH];
    always_comb begin
        priority if (sum[NW-1]) begin
            out_next = '0;
        end else if (|quot[QW-1:P]) begin
            out_next = PIX_MAX;
        end else begin
            out_next = quot[P-1:0];
        end
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (ctl.en_a) begin
            cb2_reg    <= cb2_next;
            cr2_reg    <= cr2_next;
            coef_a_reg <= coef_a;
            coef_b_reg <= coef_b;
            gain_a_reg <= gain_a_next;
        end
        if (ctl.en_b) begin
            rot_reg    <= rot_next;
            gain_b_reg <= gain_a_reg;
        end
        if (ctl.en_c) begin
            prod_reg <= prod_next;
            ofs_reg  <= ofs_next;
        end
        if (ctl.en_d) begin
            out_reg <= out_next;
        end
    end

    assign chroma_out = out_reg;

endmodule

`default_nettype wire

[rtl/video_procamp_ycbcr.sv]
// Top level of the YCbCr proc amp: brightness, contrast, hue and saturation
//
//  channel   direction  payload (low bits first)
//  s_axis    in         tdata: luma_in, blue_diff_in, red_diff_in
//  m_axis    out        tdata: luma_out, blue_diff_out, red_diff_out
//  cfg_wr    in         cfg_wr_index selects register, cfg_wr_data holds value
//
//  One pixel per clock while the output is not stalled; from input transfer to
//  output valid the data passes four register stages (input math and table read,
//  rotation multiply, gain multiply, sum and clamp).
//  Synchronous active-low reset clears the stage valid bits and loads register
//  defaults (unity gains, zero offsets and hue).
//  Each stage loads whenever it is empty or the stage after it moves, so a
//  stalled output holds its pixel while bubbles upstream still fill.
`timescale 1ns / 1ps
`default_nettype none

module video_procamp_ycbcr import vpa_pkg::*; #(
    parameter int PIXEL_BITS     = VPA_PIXEL_BITS,
    parameter int TRIG_FRAC_BITS = VPA_TRIG_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration writes
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input pixels
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // luma_in, blue_diff_in, red_diff_in
    input  wire logic [((3*PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output pixels
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // luma_out, blue_diff_out, red_diff_out
    output logic [((3*PIXEL_BITS+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int P      = PIXEL_BITS;
    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int DATA_W = ((3 * PIXEL_BITS + 7) / 8) * 8;
    localparam int STAGES = 4;

    cfg_t                 cfg;
    pipe_ctl_t            ctl;
    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    valid_next;
    logic [STAGES-1:0]    adv;
    logic signed [TW-1:0] sin_val;
    logic signed [TW-1:0] cos_val;
    logic signed [TW-1:0] cos_neg;
    logic [P-1:0]         luma_out;
    logic [P-1:0]         cb_out;
    logic [P-1:0]         cr_out;

    // register file
    vpa_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // stage advance chain, last stage first
    always_comb begin
        adv[3] = !valid_reg[3] || m_axis_tready;
        adv[2] = !valid_reg[2] || adv[3];
        adv[1] = !valid_reg[1] || adv[2];
        adv[0] = !valid_reg[0] || adv[1];
    end

    // valid bits follow the data
    always_comb begin
        valid_next[0] = adv[0] ? s_axis_tvalid : valid_reg[0];
        valid_next[1] = adv[1] ? valid_reg[0]  : valid_reg[1];
        valid_next[2] = adv[2] ? valid_reg[1]  : valid_reg[2];
        valid_next[3] = adv[3] ? valid_reg[2]  : valid_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en_a = adv[0];
    assign ctl.en_b = adv[1];
    assign ctl.en_c = adv[2];
    assign ctl.en_d = adv[3];

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[3];

    // hue to sine and cosine
    vpa_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .hue     (cfg.hue),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // red channel rotation is sin*cb + cos*cr
    assign cos_neg = -cos_val;

    vpa_luma #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_luma (
        .aclk       (aclk),
        .ctl        (ctl),
        .luma_in    (s_axis_tdata[P-1:0]),
        .contrast   (cfg.contrast),
        .brightness (cfg.brightness),
        .luma_out   (luma_out)
    );

    vpa_chroma #(
        .PIXEL_BITS     (PIXEL_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_chroma_cb (
        .aclk        (aclk),
        .ctl         (ctl),
        .cb_in       (s_axis_tdata[2*P-1:P]),
        .cr_in       (s_axis_tdata[3*P-1:2*P]),
        .coef_a      (cos_val),
        .coef_b      (sin_val),
        .saturation  (cfg.saturation),
        .chan_gain   (cfg.cb_gain),
        .chan_offset (cfg.cb_offset),
        .chroma_out  (cb_out)
    );

    vpa_chroma #(
        .PIXEL_BITS     (PIXEL_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_chroma_cr (
        .aclk        (aclk),
        .ctl         (ctl),
        .cb_in       (s_axis_tdata[2*P-1:P]),
        .cr_in       (s_axis_tdata[3*P-1:2*P]),
        .coef_a      (sin_val),
        .coef_b      (cos_neg),
        .saturation  (cfg.saturation),
        .chan_gain   (cfg.cr_gain),
        .chan_offset (cfg.cr_offset),
        .chroma_out  (cr_out)
    );

    // output packing, zero padded to whole bytes
    assign m_axis_tdata = DATA_W'({cr_out, cb_out, luma_out});

endmodule

`default_nettype wire
